// ===== rtl/core/atn_pkg.sv =====
// ---------------------------------------------------------------------------
// atn_pkg
// Shared types and fixed-point constants for the four-quadrant arctangent.
// ---------------------------------------------------------------------------
package atn_pkg;

  localparam int COORD_WIDTH_DEF     = 32;
  localparam int ANGLE_FRAC_BITS_DEF = 29;
  localparam int ACC_W               = 44;
  localparam int RATIO_W             = 33;
  localparam int Q_BITS              = 33;
  localparam int INT_FRAC            = 40;
  localparam int N_STEPS             = 11;
  localparam int MAG_W               = 48;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [RATIO_W-1:0]      ratio_t;

  typedef struct packed {
    logic zero;
    logic eq;
    logic xneg;
    logic yneg;
    logic swap;
  } atn_flags_t;

  typedef struct packed {
    atn_flags_t flags;
    ratio_t     a;
    ratio_t     a2;
  } atn_side_t;

  localparam acc_t K_INIT    = -44'sd4581298449;
  localparam acc_t K_HALF_PI = 44'sd1727108826179;
  localparam acc_t K_PI      = 44'sd3454217652358;

  localparam acc_t STEP_K [N_STEPS] = '{
    44'sd39268272421,
    -44'sd142725067067,
    44'sd274877906944,
    -44'sd268630681786,
    44'sd54975581389,
    44'sd114532461227,
    -44'sd157073089682,
    44'sd219902325555,
    -44'sd366503875925,
    44'sd1099511627776,
    44'sd0
  };

  // Steps that multiply by the squared ratio
  localparam logic [N_STEPS-1:0] STEP_A2 = 11'b01111000000;

endpackage

// ===== rtl/core/four_quadrant_arctangent_core.sv =====
// ---------------------------------------------------------------------------
// four_quadrant_arctangent_core
// Throughput: one item per cycle; the whole pipeline holds while out_stall
// is high and a result waits in the output register.
// Reset: synchronous, active low; clears all valid bits, payload is kept.
// ---------------------------------------------------------------------------
module four_quadrant_arctangent_core import atn_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COORD_WIDTH-1:0]    in_x_coord,
  input  logic signed [COORD_WIDTH-1:0]    in_y_coord,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ANGLE_FRAC_BITS+2:0] out_angle
);

  localparam int OUT_W = ANGLE_FRAC_BITS + 3;

  logic adv;

  // Front: magnitudes and ordering
  logic [COORD_WIDTH-1:0] ax, ay;
  atn_flags_t             fr_flags_nxt;
  logic                   fr_vld_r;
  atn_flags_t             fr_flags_r;
  logic [COORD_WIDTH-1:0] fr_mn_r, fr_mx_r;

  // Divider
  logic              dv_vld;
  atn_flags_t        dv_flags;
  logic [Q_BITS-1:0] dv_q;

  // Ratio
  logic [Q_BITS:0] q_inc;
  logic            a_vld_r;
  atn_side_t       a_side_r;

  // Square and Horner chain
  logic      sq_vld;
  atn_side_t sq_side;
  acc_t      sq_acc;
  atn_side_t sq_side_fix;

  logic      st_vld  [N_STEPS+1];
  atn_side_t st_side [N_STEPS+1];
  acc_t      st_acc  [N_STEPS+1];

  // Unfold and round
  acc_t       r1, r2;
  logic       uf_vld_r;
  atn_flags_t uf_flags_r;
  acc_t       uf_r;

  logic [MAG_W-1:0] mag, magr, res;
  logic             neg;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_angle_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  assign ax = in_x_coord[COORD_WIDTH-1] ? COORD_WIDTH'(~in_x_coord + 1'b1)
                                        : COORD_WIDTH'(in_x_coord);
  assign ay = in_y_coord[COORD_WIDTH-1] ? COORD_WIDTH'(~in_y_coord + 1'b1)
                                        : COORD_WIDTH'(in_y_coord);

  always_comb begin
    fr_flags_nxt.xneg = in_x_coord[COORD_WIDTH-1];
    fr_flags_nxt.yneg = in_y_coord[COORD_WIDTH-1];
    fr_flags_nxt.swap = ay > ax;
    fr_flags_nxt.eq   = ay == ax;
    fr_flags_nxt.zero = (ax == '0) && (ay == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else if (adv) begin
      fr_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fr_flags_r <= fr_flags_nxt;
      fr_mn_r    <= (ay > ax) ? ax : ay;
      fr_mx_r    <= (ay > ax) ? ay : ax;
    end
  end

  atn_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (fr_vld_r),
    .in_flags  (fr_flags_r),
    .in_mn     (fr_mn_r),
    .in_mx     (fr_mx_r),
    .out_valid (dv_vld),
    .out_flags (dv_flags),
    .out_q     (dv_q)
  );

  assign q_inc = {1'b0, dv_q} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r.flags <= dv_flags;
      a_side_r.a     <= dv_flags.eq ? ratio_t'(1) << 32 : ratio_t'(q_inc >> 1);
      a_side_r.a2    <= '0;
    end
  end

  atn_mul u_sq (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (a_vld_r),
    .in_side   (a_side_r),
    .in_mult   (a_side_r.a),
    .in_v      (acc_t'(a_side_r.a)),
    .in_k      ('0),
    .out_valid (sq_vld),
    .out_side  (sq_side),
    .out_acc   (sq_acc)
  );

  always_comb begin
    sq_side_fix    = sq_side;
    sq_side_fix.a2 = ratio_t'(sq_acc);
  end

  assign st_vld[0]  = sq_vld;
  assign st_side[0] = sq_side_fix;
  assign st_acc[0]  = K_INIT;

  for (genvar i = 0; i < N_STEPS; i++) begin : g_step
    atn_mul u_mul (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (st_vld[i]),
      .in_side   (st_side[i]),
      .in_mult   (STEP_A2[i] ? st_side[i].a2 : st_side[i].a),
      .in_v      (st_acc[i]),
      .in_k      (STEP_K[i]),
      .out_valid (st_vld[i+1]),
      .out_side  (st_side[i+1]),
      .out_acc   (st_acc[i+1])
    );
  end

  assign r1 = st_side[N_STEPS].flags.swap ? K_HALF_PI - st_acc[N_STEPS] : st_acc[N_STEPS];
  assign r2 = st_side[N_STEPS].flags.xneg ? K_PI - r1 : r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uf_vld_r <= 1'b0;
    end else if (adv) begin
      uf_vld_r <= st_vld[N_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      uf_flags_r <= st_side[N_STEPS].flags;
      uf_r       <= r2;
    end
  end

  assign mag = uf_r[ACC_W-1] ? MAG_W'(-uf_r) : MAG_W'(uf_r);

  if (ANGLE_FRAC_BITS >= INT_FRAC) begin : g_shl
    assign magr = mag << (ANGLE_FRAC_BITS - INT_FRAC);
  end else begin : g_rnd
    assign magr = (mag + (MAG_W'(1) << (INT_FRAC - ANGLE_FRAC_BITS - 1)))
                  >> (INT_FRAC - ANGLE_FRAC_BITS);
  end

  assign neg = uf_r[ACC_W-1] != uf_flags_r.yneg;
  assign res = neg ? MAG_W'(-magr) : magr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= uf_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_angle_r <= uf_flags_r.zero ? '0 : OUT_W'(res);
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

endmodule

// ===== rtl/core/atn_div.sv =====
// ---------------------------------------------------------------------------
// atn_div
// Restoring long division, one quotient bit per pipeline stage.
// ---------------------------------------------------------------------------
module atn_div import atn_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_valid,
  input  atn_flags_t             in_flags,
  input  logic [COORD_WIDTH-1:0] in_mn,
  input  logic [COORD_WIDTH-1:0] in_mx,
  output logic                   out_valid,
  output atn_flags_t             out_flags,
  output logic [Q_BITS-1:0]      out_q
);

  logic                   vld_r   [Q_BITS];
  atn_flags_t             flags_r [Q_BITS];
  logic [COORD_WIDTH-1:0] rem_r   [Q_BITS];
  logic [COORD_WIDTH-1:0] mx_r    [Q_BITS];
  logic [Q_BITS-1:0]      q_r     [Q_BITS];

  for (genvar i = 0; i < Q_BITS; i++) begin : g_stage
    logic                   vld_in;
    atn_flags_t             flags_in;
    logic [COORD_WIDTH-1:0] rem_in;
    logic [COORD_WIDTH-1:0] mx_in;
    logic [Q_BITS-1:0]      q_in;
    logic [COORD_WIDTH:0]   t;
    logic                   ge;
    logic [COORD_WIDTH-1:0] rem_nxt;

    if (i == 0) begin : g_first
      assign vld_in   = in_valid;
      assign flags_in = in_flags;
      assign rem_in   = in_mn;
      assign mx_in    = in_mx;
      assign q_in     = '0;
    end else begin : g_rest
      assign vld_in   = vld_r[i-1];
      assign flags_in = flags_r[i-1];
      assign rem_in   = rem_r[i-1];
      assign mx_in    = mx_r[i-1];
      assign q_in     = q_r[i-1];
    end

    assign t       = {rem_in, 1'b0};
    assign ge      = t >= {1'b0, mx_in};
    assign rem_nxt = ge ? COORD_WIDTH'(t - {1'b0, mx_in}) : COORD_WIDTH'(t);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        flags_r[i] <= flags_in;
        rem_r[i]   <= rem_nxt;
        mx_r[i]    <= mx_in;
        q_r[i]     <= {q_in[Q_BITS-2:0], ge};
      end
    end
  end

  assign out_valid = vld_r[Q_BITS-1];
  assign out_flags = flags_r[Q_BITS-1];
  assign out_q     = q_r[Q_BITS-1];

endmodule

// ===== rtl/core/atn_mul.sv =====
// ---------------------------------------------------------------------------
// atn_mul
// One Horner step: k + round(mult * v / 2^32), split over two stages.
// ---------------------------------------------------------------------------
module atn_mul import atn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_valid,
  input  atn_side_t in_side,
  input  ratio_t    in_mult,
  input  acc_t      in_v,
  input  acc_t      in_k,
  output logic      out_valid,
  output atn_side_t out_side,
  output acc_t      out_acc
);

  logic [ACC_W-1:0] m;
  logic [11:0]      hi;
  logic [31:0]      lo;
  logic [44:0]      ph_nxt;
  logic [64:0]      pl_nxt;

  logic             vld1_r;
  logic             neg_r;
  acc_t             k_r;
  atn_side_t        side1_r;
  logic [44:0]      ph_r;
  logic [64:0]      pl_r;

  logic [44:0]      p;
  acc_t             sp;
  acc_t             acc_nxt;

  logic             vld2_r;
  atn_side_t        side2_r;
  acc_t             acc_r;

  assign m      = in_v[ACC_W-1] ? ACC_W'(-in_v) : ACC_W'(in_v);
  assign hi     = m[ACC_W-1:32];
  assign lo     = m[31:0];
  assign ph_nxt = 45'(in_mult) * 45'(hi);
  assign pl_nxt = 65'(in_mult) * 65'(lo);

  assign p       = ph_r + 45'((pl_r + 65'h0_8000_0000) >> 32);
  assign sp      = neg_r ? -acc_t'(p[ACC_W-1:0]) : acc_t'(p[ACC_W-1:0]);
  assign acc_nxt = k_r + sp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_r   <= in_v[ACC_W-1];
      k_r     <= in_k;
      side1_r <= in_side;
      ph_r    <= ph_nxt;
      pl_r    <= pl_nxt;
      side2_r <= side1_r;
      acc_r   <= acc_nxt;
    end
  end

  assign out_valid = vld2_r;
  assign out_side  = side2_r;
  assign out_acc   = acc_r;

endmodule

// ===== rtl/core/atn_chk.sv =====
// ---------------------------------------------------------------------------
// atn_chk
// Port-level checks for the four-quadrant arctangent core.
// ---------------------------------------------------------------------------
module atn_chk import atn_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic signed [COORD_WIDTH-1:0]     in_x_coord,
  input logic signed [COORD_WIDTH-1:0]     in_y_coord,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [ANGLE_FRAC_BITS+2:0] out_angle
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_angle))
    else $error("stalled result changed");

  a_backpress: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind four_quadrant_arctangent_core atn_chk #(
  .COORD_WIDTH     (COORD_WIDTH),
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_atn_chk (.*);

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// Four-quadrant arctangent core testbench
// Drives coordinate pairs through the valid/stall input channel with random
// bursts and gaps, stalls the angle output on its own pattern, and compares
// every angle against a bit-exact fixed-point atan2 predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import atn_pkg::*;

  localparam int CW = 32;
  localparam int AFB = 29;
  localparam int OW = AFB + 3;
  localparam int STALL_LIMIT = 20000;

  localparam longint unsigned Q_ONE = 64'd1099511627776;
  localparam longint Q_M1_3 = -64'sd366503875925;
  localparam longint Q_1_5 = 64'sd219902325555;
  localparam longint Q_M1_7 = -64'sd157073089682;
  localparam longint Q_5_48 = 64'sd114532461227;
  localparam longint Q_1_20 = 64'sd54975581389;
  localparam longint Q_M43_176 = -64'sd268630681786;
  localparam longint Q_1_4 = 64'sd274877906944;
  localparam longint Q_M27_208 = -64'sd142725067067;
  localparam longint Q_1_28 = 64'sd39268272421;
  localparam longint Q_M1_240 = -64'sd4581298449;
  localparam longint Q_HALF_PI = 64'sd1727108826179;
  localparam longint Q_PI = 64'sd3454217652358;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_x_coord = '0;
  logic signed [CW-1:0] in_y_coord = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OW-1:0] out_angle;

  coord_t pending_q[$];
  logic signed [OW-1:0] angle_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_sender = 1'b0;
  bit long_hold = 1'b0;
  int gap_left = 0;
  int burst_left = 0;

  four_quadrant_arctangent_core #(.COORD_WIDTH(CW), .ANGLE_FRAC_BITS(AFB)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord), .out_valid(out_valid),
    .out_stall(out_stall), .out_angle(out_angle)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned mag_of(logic signed [CW-1:0] v);
    longint signed s;
    s = longint'(v);
    return s < 0 ? longint'(-s) : s;
  endfunction

  function automatic longint scale_q32(longint unsigned a, longint v);
    longint unsigned m, p;
    m = v < 0 ? -v : v;
    p = a * (m >> 32) + ((a * (m & 64'hFFFF_FFFF) + 64'h8000_0000) >> 32);
    return v < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic signed [OW-1:0] atan2_fixed(coord_t c);
    longint unsigned ax, ay, mn, mx, rem, q, a, a2, mag;
    longint acc;
    ax = mag_of(c.x);
    ay = mag_of(c.y);
    mn = ax < ay ? ax : ay;
    mx = ax < ay ? ay : ax;
    if (mx == 0) return '0;
    if (mn == mx) a = 64'd1 << 32;
    else begin
      rem = mn;
      q = 0;
      for (int i = 0; i < 33; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= mx) begin
          rem -= mx;
          q |= 1;
        end
      end
      a = (q + 1) >> 1;
    end
    a2 = scale_q32(a, longint'(a));
    acc = Q_M1_240;
    acc = Q_1_28 + scale_q32(a, acc);
    acc = Q_M27_208 + scale_q32(a, acc);
    acc = Q_1_4 + scale_q32(a, acc);
    acc = Q_M43_176 + scale_q32(a, acc);
    acc = Q_1_20 + scale_q32(a, acc);
    acc = Q_5_48 + scale_q32(a, acc);
    acc = Q_M1_7 + scale_q32(a2, acc);
    acc = Q_1_5 + scale_q32(a2, acc);
    acc = Q_M1_3 + scale_q32(a2, acc);
    acc = longint'(Q_ONE) + scale_q32(a2, acc);
    acc = scale_q32(a, acc);
    if (ay > ax) acc = Q_HALF_PI - acc;
    if (c.x[CW-1]) acc = Q_PI - acc;
    mag = acc < 0 ? -acc : acc;
    mag = (mag + (64'd1 << (40 - AFB - 1))) >> (40 - AFB);
    if ((acc < 0) != c.y[CW-1]) mag = -mag;
    return mag[OW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20) - 10;
      1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(CW-1){1'b0}}} | $urandom_range(0, 3);
      2: return {1'b0, {(CW-1){1'b1}}} - $urandom_range(0, 3);
      3: return $signed($urandom()) >>> $urandom_range(0, 30);
      default: return $urandom();
    endcase
  endfunction

  task automatic add_pair(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    coord_t c;
    c.x = x;
    c.y = y;
    pending_q = {pending_q, c};
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (hold_sender || gap_left > 0 || pending_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_valid <= 1'b1;
        in_x_coord <= pending_q[0].x;
        in_y_coord <= pending_q[0].y;
        void'(pending_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else case ($urandom_range(0, 7))
      0, 1: out_stall <= 1'b1;
      default: out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        coord_t c;
        c.x = in_x_coord;
        c.y = in_y_coord;
        angle_q = {angle_q, atan2_fixed(c)};
      end
      if (out_valid && !out_stall) begin
        if (angle_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected angle %0d", out_angle);
        end else begin
          if (out_angle !== angle_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("angle expected %0d got %0d", angle_q[0], out_angle);
          end
          void'(angle_q.pop_front());
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic signed [CW-1:0] mneg;
    mneg = {1'b1, {(CW-1){1'b0}}};
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    add_pair(0, 0);
    add_pair(5, 0);
    add_pair(-5, 0);
    add_pair(0, 5);
    add_pair(0, -5);
    add_pair(7, 7);
    add_pair(-7, 7);
    add_pair(7, -7);
    add_pair(-7, -7);
    add_pair(mneg, 0);
    add_pair(0, mneg);
    add_pair(mneg, mneg);
    add_pair(mneg, -1);
    add_pair(mneg, 1);
    add_pair(-1, mneg);
    add_pair(32'sh7fffffff, mneg);
    add_pair(32'sh7fffffff, 32'sh7fffffff);
    add_pair(32'sh7fffffff, 1);
    add_pair(1, 32'sh7fffffff);
    add_pair(mneg, 32'sh7fffffff);
    add_pair(-1, 0);
    add_pair(3, -1000);
    add_pair(-1000, 3);
    wait (pending_q.size() == 0);
    long_hold = 1'b1;
    for (int i = 0; i < 150; i++) add_pair(rand_coord(), rand_coord());
    repeat (200) @(posedge clk);
    long_hold = 1'b0;
    wait (pending_q.size() == 0);
    @(negedge clk) hold_sender = 1'b1;
    wait (!in_valid);
    wait (angle_q.size() == 0);
    @(negedge clk) hold_sender = 1'b0;
    for (int i = 0; i < 450; i++) add_pair(rand_coord(), rand_coord());
    wait (pending_q.size() == 0);
    wait (!in_valid);
    wait (angle_q.size() == 0);
    repeat (80) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/atn_pkg.sv
rtl/core/atn_div.sv
rtl/core/atn_mul.sv
rtl/core/four_quadrant_arctangent_core.sv
rtl/core/atn_chk.sv
test/testbench.sv
